// File: rtl/sps_pkg.sv
package sps_pkg;

	localparam int unsigned POS_W      = 12;
	localparam int unsigned TIMER_W    = 8;
	localparam int unsigned NUM_SERVOS = 2;

	localparam logic [POS_W-1:0]   POS_RESET   = 12'h400;
	localparam logic [POS_W-1:0]   POS_MAX     = 12'hFFF;
	localparam logic [TIMER_W-1:0] GAP_PERIODS = 8'd25;

	typedef enum logic [1:0] {
		FUNC_TICK = 2'd0,
		FUNC_SET  = 2'd1,
		FUNC_READ = 2'd2,
		FUNC_NONE = 2'd3
	} func_t;

	typedef enum logic [0:0] {
		REG_MIN_POSITION = 1'b0,
		REG_MAX_POSITION = 1'b1
	} reg_idx_t;

	typedef struct packed {
		func_t            func;
		logic             servo_select;
		logic [POS_W-1:0] new_position;
	} item_t;

	typedef struct packed {
		logic             pulse_0;
		logic             pulse_1;
		logic [POS_W-1:0] read_position;
	} result_t;

	typedef struct packed {
		logic [POS_W-1:0] min_position;
		logic [POS_W-1:0] max_position;
	} cfg_t;

endpackage

// File: rtl/sps_cfg_regs.sv
module sps_cfg_regs (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [2:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	output sps_pkg::cfg_t      cfg
);
	import sps_pkg::*;

	logic [POS_W-1:0] min_q;
	logic [POS_W-1:0] max_q;
	reg_idx_t         idx;
	logic             wr_en;

	assign pready = 1'b1;
	assign idx    = reg_idx_t'(paddr[2]);
	assign wr_en  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q <= '0;
			max_q <= POS_MAX;
		end else if (wr_en) begin
			unique case (idx)
				REG_MIN_POSITION: min_q <= pwdata[POS_W-1:0];
				REG_MAX_POSITION: max_q <= pwdata[POS_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (idx)
			REG_MIN_POSITION: prdata = {{(32-POS_W){1'b0}}, min_q};
			REG_MAX_POSITION: prdata = {{(32-POS_W){1'b0}}, max_q};
			default: prdata = '0;
		endcase
	end

	assign cfg.min_position = min_q;
	assign cfg.max_position = max_q;

endmodule

// File: rtl/sps_core.sv
module sps_core (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  sps_pkg::item_t   item,
	input  sps_pkg::cfg_t    cfg,
	output sps_pkg::result_t result
);
	import sps_pkg::*;

	typedef enum logic [1:0] {
		PH_PULSE0 = 2'd0,
		PH_PULSE1 = 2'd1,
		PH_GAP    = 2'd2,
		PH_UNUSED = 2'd3
	} phase_t;

	logic [TIMER_W-1:0] timer_q, timer_d;
	logic [TIMER_W-1:0] count_q, count_d;
	phase_t             phase_q, phase_d;
	logic [POS_W-1:0]   pos_q [NUM_SERVOS];
	logic [1:0]         lvl_q, lvl_d;
	logic [TIMER_W-1:0] timer_inc;
	logic [TIMER_W-1:0] count_dec;
	logic [POS_W-1:0]   start_pos;
	logic [TIMER_W-1:0] start_low;
	logic [TIMER_W-1:0] start_high;
	logic [POS_W-1:0]   clamp_hi;
	logic [POS_W-1:0]   clamp_pos;

	assign timer_inc  = timer_q + 8'd1;
	assign count_dec  = count_q - 8'd1;
	assign start_pos  = (phase_q == PH_PULSE0) ? pos_q[0] : pos_q[1];
	assign start_low  = start_pos[7:0];
	assign start_high = {{(2*TIMER_W-POS_W){1'b0}}, start_pos[POS_W-1:TIMER_W]};
	assign clamp_hi   = (item.new_position > cfg.max_position) ?
	                    cfg.max_position : item.new_position;
	assign clamp_pos  = (clamp_hi < cfg.min_position) ? cfg.min_position : clamp_hi;

	always_comb begin
		timer_d = timer_q;
		count_d = count_q;
		phase_d = phase_q;
		lvl_d   = lvl_q;
		if (item.func == FUNC_TICK) begin
			timer_d = timer_inc;
			if (timer_inc == '0) begin
				count_d = count_dec;
				if (count_dec == '0 || count_dec[TIMER_W-1]) begin
					unique case (phase_q)
						PH_PULSE0, PH_PULSE1: begin
							lvl_d   = (phase_q == PH_PULSE0) ? {lvl_q[1], 1'b1} : 2'b10;
							phase_d = (phase_q == PH_PULSE0) ? PH_PULSE1 : PH_GAP;
							if (start_low != '0) begin
								timer_d = 8'd0 - start_low;
								count_d = start_high;
							end else begin
								timer_d = '0;
								count_d = start_high - 8'd1;
							end
						end
						PH_GAP, PH_UNUSED: begin
							lvl_d   = {1'b0, lvl_q[0]};
							count_d = GAP_PERIODS;
							phase_d = PH_PULSE0;
						end
						default: ;
					endcase
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timer_q  <= '0;
			count_q  <= 8'd1;
			phase_q  <= PH_PULSE0;
			lvl_q    <= '0;
			pos_q[0] <= POS_RESET;
			pos_q[1] <= POS_RESET;
		end else if (en) begin
			timer_q <= timer_d;
			count_q <= count_d;
			phase_q <= phase_d;
			lvl_q   <= lvl_d;
			if (item.func == FUNC_SET) begin
				pos_q[item.servo_select] <= clamp_pos;
			end
		end
	end

	always_comb begin
		result.pulse_0       = lvl_d[0];
		result.pulse_1       = lvl_d[1];
		result.read_position = (item.func == FUNC_READ) ? pos_q[item.servo_select] : '0;
	end

endmodule

// File: rtl/two_channel_servo_pulse_sequencer_top.sv
// Two-channel servo pulse sequencer. Each input word is a tick, a position set or a
// position read, selected by s_axis_tuser; every word yields exactly one output word
// carrying both servo levels after that word and, for reads, the stored position.
// A word is registered at the input, processed by combinational compare and count logic,
// and its result registered at the output, so one word is accepted every clock cycle
// while the output is not stalled. While a result waits, the input register can take
// one word and then holds it. The min and max clamp registers sit at byte addresses
// 0 and 4 of the APB port and should be written only while no words are in flight.
module two_channel_servo_pulse_sequencer_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,  // servo_select[0], new_position[12:1], zero fill
	input  logic [1:0]  s_axis_tuser,  // func[1:0]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,  // pulse_0[0], pulse_1[1], read_position[13:2]
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import sps_pkg::*;

	item_t   item_s1;
	logic    valid_s1;
	result_t res_d;
	result_t res_s2;
	logic    valid_s2;
	logic    advance;
	cfg_t    cfg;

	assign advance       = valid_s1 && (!valid_s2 || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (s_axis_tready) begin
				valid_s1 <= s_axis_tvalid;
			end
			if (advance) begin
				valid_s2 <= 1'b1;
			end else if (m_axis_tready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			item_s1.func         <= func_t'(s_axis_tuser);
			item_s1.servo_select <= s_axis_tdata[0];
			item_s1.new_position <= s_axis_tdata[POS_W:1];
		end
		if (advance) begin
			res_s2 <= res_d;
		end
	end

	sps_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	sps_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (advance),
		.item   (item_s1),
		.cfg    (cfg),
		.result (res_d)
	);

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = {2'b00, res_s2.read_position, res_s2.pulse_1, res_s2.pulse_0};

endmodule

// File: test/servo_word_checker.sv
module servo_word_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,  // servo_select[0], new_position[12:1], zero fill
	input  logic [1:0]  s_axis_tuser,  // func[1:0]
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic [15:0] m_axis_tdata,  // pulse_0[0], pulse_1[1], read_position[13:2]
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	input  logic        pready,
	output int          error_count,
	output int          pending_count
);
	timeunit 1ns;
	timeprecision 1ps;

	import sps_pkg::*;

	localparam int REPORT_LIMIT = 10;

	localparam logic [1:0] PH_PULSE_0 = 2'd0;
	localparam logic [1:0] PH_PULSE_1 = 2'd1;
	localparam logic [1:0] PH_GAP     = 2'd2;

	logic [TIMER_W-1:0] tick_cnt;
	logic [TIMER_W-1:0] period_cnt;
	logic [1:0]         seq_phase;
	logic [POS_W-1:0]   servo_pos [NUM_SERVOS];
	logic [1:0]         pin_levels;
	logic [POS_W-1:0]   clamp_lo;
	logic [POS_W-1:0]   clamp_hi;
	result_t            servo_words [$];
	int                 mismatches;

	task automatic load_pulse(input logic [POS_W-1:0] pos);
		period_cnt = {4'b0000, pos[11:8]};
		if (pos[7:0] != 8'h00) begin
			tick_cnt = 8'h00 - pos[7:0];
		end else begin
			tick_cnt = 8'h00;
			period_cnt = period_cnt - 8'd1;
		end
	endtask

	task automatic sequencer_step(input item_t it, output result_t res);
		logic [POS_W-1:0] p;
		res.read_position = '0;
		case (it.func)
			FUNC_TICK: begin
				tick_cnt = tick_cnt + 8'd1;
				if (tick_cnt == 8'h00) begin
					period_cnt = period_cnt - 8'd1;
					if (period_cnt == 8'h00 || period_cnt[7]) begin
						case (seq_phase)
							PH_PULSE_0: begin
								pin_levels[0] = 1'b1;
								load_pulse(servo_pos[0]);
								seq_phase = PH_PULSE_1;
							end
							PH_PULSE_1: begin
								pin_levels = 2'b10;
								load_pulse(servo_pos[1]);
								seq_phase = PH_GAP;
							end
							default: begin
								// The unused phase code behaves like the gap.
								pin_levels[1] = 1'b0;
								period_cnt = GAP_PERIODS;
								seq_phase = PH_PULSE_0;
							end
						endcase
					end
				end
			end
			FUNC_SET: begin
				p = it.new_position;
				if (p > clamp_hi) p = clamp_hi;
				if (p < clamp_lo) p = clamp_lo;
				servo_pos[it.servo_select] = p;
			end
			FUNC_READ: res.read_position = servo_pos[it.servo_select];
			default: ;
		endcase
		res.pulse_0 = pin_levels[0];
		res.pulse_1 = pin_levels[1];
	endtask

	always @(posedge clk) begin
		item_t   item;
		result_t seen;
		result_t want;
		if (!arst_n) begin
			tick_cnt = '0;
			period_cnt = 8'd1;
			seq_phase = PH_PULSE_0;
			servo_pos[0] = POS_RESET;
			servo_pos[1] = POS_RESET;
			pin_levels = 2'b00;
			clamp_lo = '0;
			clamp_hi = POS_MAX;
			servo_words.delete();
			mismatches = 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (reg_idx_t'(paddr[2]))
					REG_MIN_POSITION: clamp_lo = pwdata[POS_W-1:0];
					REG_MAX_POSITION: clamp_hi = pwdata[POS_W-1:0];
					default: ;
				endcase
			end
			if (m_axis_tvalid && m_axis_tready) begin
				seen.pulse_0 = m_axis_tdata[0];
				seen.pulse_1 = m_axis_tdata[1];
				seen.read_position = m_axis_tdata[13:2];
				if (servo_words.size() == 0) begin
					mismatches++;
					if (mismatches <= REPORT_LIMIT)
						$display("%t: unexpected output word %04h", $realtime, m_axis_tdata);
				end else begin
					want = servo_words.pop_front();
					if (seen.pulse_0 != want.pulse_0 || seen.pulse_1 != want.pulse_1 ||
							seen.read_position != want.read_position ||
							m_axis_tdata[15:14] != 2'b00) begin
						mismatches++;
						if (mismatches <= REPORT_LIMIT)
							$display("%t: expected p0=%0b p1=%0b pos=%03h, got p0=%0b p1=%0b pos=%03h fill=%0h",
								$realtime, want.pulse_0, want.pulse_1, want.read_position,
								seen.pulse_0, seen.pulse_1, seen.read_position,
								m_axis_tdata[15:14]);
					end
				end
			end
			if (s_axis_tvalid && s_axis_tready) begin
				item.func = func_t'(s_axis_tuser);
				item.servo_select = s_axis_tdata[0];
				item.new_position = s_axis_tdata[12:1];
				sequencer_step(item, want);
				servo_words.push_back(want);
			end
		end
		error_count <= mismatches + servo_words.size();
		pending_count <= servo_words.size();
	end

endmodule

// File: test/tb_top.sv
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import sps_pkg::*;

	localparam int SEG_WORDS    = 290;
	localparam int RX_LONG_HOLD = 400;
	localparam int QUIET_LIMIT  = 2000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [15:0] s_axis_tdata = '0;
	logic [1:0]  s_axis_tuser = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [15:0] m_axis_tdata;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	int error_count;
	int pending_count;
	int tx_idle_max = 0;
	int rx_idle_max = 0;
	bit rx_hold_req = 1'b0;
	int quiet_cycles = 0;

	two_channel_servo_pulse_sequencer_top u_top (.*);

	servo_word_checker u_checker (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	task automatic send_word(input func_t f, input logic sel, input logic [POS_W-1:0] pos);
		int gap;
		gap = $urandom_range(0, tx_idle_max);
		if (gap != 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= f;
		s_axis_tdata <= {3'b000, pos, sel};
		do @(posedge clk); while (!s_axis_tready);
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [POS_W-1:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= 32'(val);
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	task automatic drain();
		s_axis_tvalid <= 1'b0;
		do @(posedge clk); while (pending_count != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic run_segment(input logic [POS_W-1:0] lo, input logic [POS_W-1:0] hi,
			input int tx_max, input int rx_max, input bit hold);
		int               pick;
		func_t            f;
		logic [POS_W-1:0] pos;
		drain();
		write_reg(REG_MIN_POSITION, lo);
		write_reg(REG_MAX_POSITION, hi);
		tx_idle_max = tx_max;
		rx_idle_max = rx_max;
		rx_hold_req = hold;
		repeat (SEG_WORDS) begin
			pick = $urandom_range(0, 99);
			if (pick < 90)
				f = FUNC_TICK;
			else if (pick < 95)
				f = FUNC_SET;
			else if (pick < 99)
				f = FUNC_READ;
			else
				f = FUNC_NONE;
			if ($urandom_range(0, 1)) begin
				pos = 12'($urandom);
			end else begin
				pos[11:8] = 4'($urandom_range(0, 2));
				pos[7:0] = ($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom);
			end
			send_word(f, 1'($urandom), pos);
		end
	endtask

	initial begin
		int hold;
		wait (arst_n === 1'b1);
		forever begin
			hold = $urandom_range(0, rx_idle_max);
			if (rx_hold_req) begin
				rx_hold_req = 1'b0;
				hold = RX_LONG_HOLD;
			end
			if (hold != 0) begin
				m_axis_tready <= 1'b0;
				repeat (hold) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (!m_axis_tvalid);
		end
	end

	always @(posedge clk) begin
		if (!arst_n) begin
			quiet_cycles <= 0;
		end else if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
				(psel && penable && pready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		tx_idle_max = 3;
		rx_idle_max = 3;

		send_word(FUNC_READ, 1'b0, 12'h000);
		send_word(FUNC_READ, 1'b1, 12'hFFF);
		send_word(FUNC_NONE, 1'b1, 12'hFFF);
		send_word(FUNC_SET,  1'b0, 12'hFFF);
		send_word(FUNC_READ, 1'b0, 12'h000);
		send_word(FUNC_SET,  1'b1, 12'h000);
		send_word(FUNC_READ, 1'b1, 12'h000);
		send_word(FUNC_TICK, 1'b1, 12'hFFF);
		send_word(FUNC_TICK, 1'b0, 12'h000);
		send_word(FUNC_SET,  1'b0, 12'h100);
		send_word(FUNC_READ, 1'b0, 12'h000);

		// Crossed bounds: the lower bound must win.
		drain();
		write_reg(REG_MIN_POSITION, 12'h800);
		write_reg(REG_MAX_POSITION, 12'h300);
		send_word(FUNC_SET,  1'b1, 12'h100);
		send_word(FUNC_READ, 1'b1, 12'h000);
		send_word(FUNC_SET,  1'b0, 12'hFFF);
		send_word(FUNC_READ, 1'b0, 12'h000);

		drain();
		write_reg(REG_MIN_POSITION, 12'h200);
		write_reg(REG_MAX_POSITION, 12'hA00);
		send_word(FUNC_SET,  1'b0, 12'hFFF);
		send_word(FUNC_READ, 1'b0, 12'h000);
		send_word(FUNC_SET,  1'b1, 12'h000);
		send_word(FUNC_READ, 1'b1, 12'h000);
		send_word(FUNC_SET,  1'b0, 12'h555);
		send_word(FUNC_READ, 1'b0, 12'h000);

		// A zero position makes the period count wrap below zero.
		drain();
		write_reg(REG_MIN_POSITION, 12'h000);
		write_reg(REG_MAX_POSITION, 12'hFFF);
		send_word(FUNC_SET, 1'b0, 12'h000);
		send_word(FUNC_SET, 1'b1, 12'h0FF);

		run_segment(12'h000, 12'hFFF, 0, 0, 1'b0);
		run_segment(12'h000, 12'h000, 0, 19, 1'b1);
		run_segment(12'hFFF, 12'hFFF, 19, 0, 1'b0);
		run_segment(12'h900, 12'h200, 19, 19, 1'b0);
		run_segment(12'($urandom_range(0, 12'h1FF)), 12'($urandom_range(12'h100, 12'h5FF)),
			3, 3, 1'b0);
		run_segment(12'h000, 12'hFFF, 19, 19, 1'b0);

		drain();
		repeat (4) @(posedge clk);
		if (error_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

// File: sim.f
rtl/sps_pkg.sv
rtl/sps_cfg_regs.sv
rtl/sps_core.sv
rtl/two_channel_servo_pulse_sequencer_top.sv
test/servo_word_checker.sv
test/tb_top.sv
